### hw/rtl/hrhp_pkg.sv
// Shared types and constants for the HTTP request header parser.
// No dependencies; imported by every other RTL file of the block.
`default_nettype none

package hrhp_pkg;

  // Parser position, one-hot
  typedef enum logic [19:0] {
    ST_METHOD_START       = 20'h00001,
    ST_METHOD             = 20'h00002,
    ST_URI                = 20'h00004,
    ST_VER_H              = 20'h00008,
    ST_VER_T1             = 20'h00010,
    ST_VER_T2             = 20'h00020,
    ST_VER_P              = 20'h00040,
    ST_VER_SLASH          = 20'h00080,
    ST_MAJOR_START        = 20'h00100,
    ST_MAJOR              = 20'h00200,
    ST_MINOR_START        = 20'h00400,
    ST_MINOR              = 20'h00800,
    ST_LF1                = 20'h01000,
    ST_LINE_START         = 20'h02000,
    ST_LWS                = 20'h04000,
    ST_NAME               = 20'h08000,
    ST_SPACE_BEFORE_VALUE = 20'h10000,
    ST_VALUE              = 20'h20000,
    ST_LF2                = 20'h40000,
    ST_LF3                = 20'h80000
  } parse_state_t;

  // Result status codes
  localparam logic [1:0] RES_MORE = 2'd0;
  localparam logic [1:0] RES_DONE = 2'd1;
  localparam logic [1:0] RES_BAD  = 2'd2;

  // Byte class codes
  localparam logic [2:0] CLS_NONE   = 3'd0;
  localparam logic [2:0] CLS_METHOD = 3'd1;
  localparam logic [2:0] CLS_URI    = 3'd2;
  localparam logic [2:0] CLS_NAME   = 3'd3;
  localparam logic [2:0] CLS_VALUE  = 3'd4;

  // Literal characters the parser looks for
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Character class flags from the classifier
  typedef struct packed {
    logic is_token;
    logic is_ctl;
    logic is_num;
    logic is_wsp;
  } char_flags_t;

  // Per-byte result, apart from the version numbers
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] byte_class;
    logic       new_header;
  } hrhp_result_t;

endpackage

`default_nettype wire

### hw/rtl/hrhp_char_class.sv
// Byte classifier: token, control, digit and linear whitespace flags.
// Depends on hrhp_pkg for the flag struct.
`default_nettype none

module hrhp_char_class
  import hrhp_pkg::*;
(
  input  wire logic [7:0]  char_i,
  output char_flags_t      flags_o
);

  logic ctl;
  logic sep;

  // Control: 0..31 or DEL
  assign ctl = (char_i <= 8'd31) || (char_i == 8'd127);

  // Separators as listed for HTTP tokens
  always_comb begin
    case (char_i)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
  end

  assign flags_o.is_ctl   = ctl;
  assign flags_o.is_token = !char_i[7] && !ctl && !sep;
  assign flags_o.is_num   = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign flags_o.is_wsp   = (char_i == CH_SP) || (char_i == CH_HT);

endmodule

`default_nettype wire

### hw/rtl/hrhp_core.sv
// Parser state registers and the one-byte transition logic.
// Depends on hrhp_pkg and hrhp_char_class.
`default_nettype none

module hrhp_core
  import hrhp_pkg::*;
#(
  parameter int VERSION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_i,
  input  wire logic [7:0]  char_i,
  input  wire logic        restart_i,
  output hrhp_result_t     result_o,
  output logic [7:0]       version_major_o,
  output logic [7:0]       version_minor_o
);

  localparam int AccW = VERSION_BITS + 4;
  localparam int ExtW = (VERSION_BITS > 8) ? VERSION_BITS : 8;
  localparam logic [VERSION_BITS-1:0] VerMax = '1;

  parse_state_t            state_r, state_nxt, state_cur;
  logic                    hh_r, hh_nxt, hh_cur;
  logic [VERSION_BITS-1:0] maj_r, maj_nxt, maj_cur;
  logic [VERSION_BITS-1:0] min_r, min_nxt, min_cur;
  logic [VERSION_BITS-1:0] maj_dig, min_dig;
  logic [ExtW-1:0]         maj_ext, min_ext;
  char_flags_t             fl;

  hrhp_char_class u_class (
    .char_i  (char_i),
    .flags_o (fl)
  );

  // acc*10 + digit, saturating at the top of the accumulator range
  function automatic logic [VERSION_BITS-1:0] acc_digit(
    input logic [VERSION_BITS-1:0] acc,
    input logic [3:0]              dig
  );
    logic [AccW-1:0] sum;
    sum = (AccW'(acc) << 3) + (AccW'(acc) << 1) + AccW'(dig);
    if (sum[AccW-1:VERSION_BITS] != '0) return VerMax;
    return sum[VERSION_BITS-1:0];
  endfunction

  // Restart applies before the byte is consumed
  assign state_cur = restart_i ? ST_METHOD_START : state_r;
  assign hh_cur    = restart_i ? 1'b0 : hh_r;
  assign maj_cur   = restart_i ? '0 : maj_r;
  assign min_cur   = restart_i ? '0 : min_r;
  assign maj_dig   = acc_digit(maj_cur, char_i[3:0]);
  assign min_dig   = acc_digit(min_cur, char_i[3:0]);

  // Transition; a bad byte keeps the (post-restart) state
  always_comb begin
    state_nxt           = state_cur;
    hh_nxt              = hh_cur;
    maj_nxt             = maj_cur;
    min_nxt             = min_cur;
    result_o.status     = RES_MORE;
    result_o.byte_class = CLS_NONE;
    result_o.new_header = 1'b0;
    unique case (state_cur)
      ST_METHOD_START: begin
        if (fl.is_token) begin
          state_nxt = ST_METHOD;
          result_o.byte_class = CLS_METHOD;
        end else result_o.status = RES_BAD;
      end
      ST_METHOD: begin
        if (char_i == CH_SP) state_nxt = ST_URI;
        else if (fl.is_token) result_o.byte_class = CLS_METHOD;
        else result_o.status = RES_BAD;
      end
      ST_URI: begin
        if (char_i == CH_SP) state_nxt = ST_VER_H;
        else if (fl.is_ctl) result_o.status = RES_BAD;
        else result_o.byte_class = CLS_URI;
      end
      ST_VER_H: begin
        if (char_i == CH_H) state_nxt = ST_VER_T1;
        else result_o.status = RES_BAD;
      end
      ST_VER_T1: begin
        if (char_i == CH_T) state_nxt = ST_VER_T2;
        else result_o.status = RES_BAD;
      end
      ST_VER_T2: begin
        if (char_i == CH_T) state_nxt = ST_VER_P;
        else result_o.status = RES_BAD;
      end
      ST_VER_P: begin
        if (char_i == CH_P) state_nxt = ST_VER_SLASH;
        else result_o.status = RES_BAD;
      end
      ST_VER_SLASH: begin
        if (char_i == CH_SLASH) begin
          maj_nxt   = '0;
          min_nxt   = '0;
          state_nxt = ST_MAJOR_START;
        end else result_o.status = RES_BAD;
      end
      ST_MAJOR_START: begin
        if (fl.is_num) begin
          maj_nxt   = maj_dig;
          state_nxt = ST_MAJOR;
        end else result_o.status = RES_BAD;
      end
      ST_MAJOR: begin
        if (char_i == CH_DOT) state_nxt = ST_MINOR_START;
        else if (fl.is_num) maj_nxt = maj_dig;
        else result_o.status = RES_BAD;
      end
      ST_MINOR_START: begin
        if (fl.is_num) begin
          min_nxt   = min_dig;
          state_nxt = ST_MINOR;
        end else result_o.status = RES_BAD;
      end
      ST_MINOR: begin
        if (char_i == CH_CR) state_nxt = ST_LF1;
        else if (fl.is_num) min_nxt = min_dig;
        else result_o.status = RES_BAD;
      end
      ST_LF1: begin
        if (char_i == CH_LF) state_nxt = ST_LINE_START;
        else result_o.status = RES_BAD;
      end
      ST_LINE_START: begin
        if (char_i == CH_CR) state_nxt = ST_LF3;
        else if (hh_cur && fl.is_wsp) state_nxt = ST_LWS;
        else if (fl.is_token) begin
          hh_nxt              = 1'b1;
          state_nxt           = ST_NAME;
          result_o.byte_class = CLS_NAME;
          result_o.new_header = 1'b1;
        end else result_o.status = RES_BAD;
      end
      ST_LWS: begin
        if (char_i == CH_CR) state_nxt = ST_LF2;
        else if (fl.is_wsp) state_nxt = ST_LWS;
        else if (fl.is_ctl) result_o.status = RES_BAD;
        else begin
          state_nxt           = ST_VALUE;
          result_o.byte_class = CLS_VALUE;
        end
      end
      ST_NAME: begin
        if (char_i == CH_COLON) state_nxt = ST_SPACE_BEFORE_VALUE;
        else if (fl.is_token) result_o.byte_class = CLS_NAME;
        else result_o.status = RES_BAD;
      end
      ST_SPACE_BEFORE_VALUE: begin
        if (char_i == CH_SP) state_nxt = ST_VALUE;
        else result_o.status = RES_BAD;
      end
      ST_VALUE: begin
        if (char_i == CH_CR) state_nxt = ST_LF2;
        else if (fl.is_ctl) result_o.status = RES_BAD;
        else result_o.byte_class = CLS_VALUE;
      end
      ST_LF2: begin
        if (char_i == CH_LF) state_nxt = ST_LINE_START;
        else result_o.status = RES_BAD;
      end
      ST_LF3: begin
        result_o.status = (char_i == CH_LF) ? RES_DONE : RES_BAD;
      end
      default: result_o.status = RES_BAD;
    endcase
  end

  // Version outputs carry the low byte of the updated accumulators
  assign maj_ext         = ExtW'(maj_nxt);
  assign min_ext         = ExtW'(min_nxt);
  assign version_major_o = maj_ext[7:0];
  assign version_minor_o = min_ext[7:0];

  // State registers, updated once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_METHOD_START;
      hh_r    <= 1'b0;
      maj_r   <= '0;
      min_r   <= '0;
    end else if (step_i) begin
      state_r <= state_nxt;
      hh_r    <= hh_nxt;
      maj_r   <= maj_nxt;
      min_r   <= min_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/http_request_header_parser.sv
// HTTP request header parser, top level: input register, parser core, result register.
// A new byte can be taken every cycle unless out_stall fills both stages; each byte
// yields exactly one result, held first in the input register and then in the result
// register. The rate is set by the combinational state transition in hrhp_core. Bytes
// are classified as method, URI, header name or value; version numbers saturate at
// 2^VERSION_BITS-1 and are shown as their low eight bits. Raise in_begin_request
// with the first byte of each request.
// Depends on hrhp_pkg and hrhp_core.
`default_nettype none

module http_request_header_parser
  import hrhp_pkg::*;
#(
  parameter int VERSION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_begin_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [2:0]       out_byte_class,
  output logic             out_new_header,
  output logic [7:0]       out_byte,
  output logic [7:0]       out_version_major,
  output logic [7:0]       out_version_minor
);

  logic         s0_valid_r, s0_valid_nxt;
  logic [7:0]   s0_byte_r;
  logic         s0_begin_r;
  logic         s1_valid_r, s1_valid_nxt;
  hrhp_result_t s1_res_r;
  logic [7:0]   s1_byte_r, s1_maj_r, s1_min_r;
  logic         s0_free, s1_free, in_fire, s0_move;
  hrhp_result_t core_res;
  logic [7:0]   core_maj, core_min;

  // Handshake: each stage frees when the one after it can take its transaction
  assign s1_free  = !s1_valid_r || !out_stall;
  assign s0_free  = !s0_valid_r || s1_free;
  assign in_stall = !s0_free;
  assign in_fire  = in_valid && s0_free;
  assign s0_move  = s0_valid_r && s1_free;

  assign s0_valid_nxt = s0_free ? in_valid : 1'b1;
  assign s1_valid_nxt = s1_free ? s0_valid_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_byte_r  <= in_byte;
      s0_begin_r <= in_begin_request;
    end
  end

  hrhp_core #(
    .VERSION_BITS (VERSION_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_i          (s0_move),
    .char_i          (s0_byte_r),
    .restart_i       (s0_begin_r),
    .result_o        (core_res),
    .version_major_o (core_maj),
    .version_minor_o (core_min)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (s0_move) begin
      s1_res_r  <= core_res;
      s1_byte_r <= s0_byte_r;
      s1_maj_r  <= core_maj;
      s1_min_r  <= core_min;
    end
  end

  assign out_valid         = s1_valid_r;
  assign out_status        = s1_res_r.status;
  assign out_byte_class    = s1_res_r.byte_class;
  assign out_new_header    = s1_res_r.new_header;
  assign out_byte          = s1_byte_r;
  assign out_version_major = s1_maj_r;
  assign out_version_minor = s1_min_r;

  // Bad bytes carry no class and no header start
  a_bad_unclassified: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == RES_BAD) |-> (out_byte_class == CLS_NONE && !out_new_header))
    else $error("bad byte carries a class");

  // A header start is always a header name byte
  a_new_header_is_name: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_header) |-> (out_byte_class == CLS_NAME))
    else $error("header start without name class");

  // Input stalls only when both stages are full and the output is stalled
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_valid_r && s1_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // A buffered byte moves on without a bubble when the output is free
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !out_stall) |=> out_valid)
    else $error("result lost a cycle");

endmodule

`default_nettype wire
